FILE: rtl/core/ple_pkg.sv
package ple_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 3;
    localparam int FOUND_W = 6;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_POS   = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic start_up;
        logic start_dn;
        logic start_scan;
        logic shift_up;
        logic shift_dn;
        logic scan;
        logic rd_pos;
        logic cap_value;
        logic put;
        logic drop;
        logic hit;
        logic miss;
        logic out_load;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             ok;
        logic             ins_direct;
        logic             rm_direct;
        logic             up_last;
        logic             dn_last;
        logic             scan_hit;
        logic             scan_end;
    } sts_t;

endpackage

FILE: rtl/core/ple_datapath.sv
module ple_datapath #(
    parameter int CAPACITY = ple_pkg::DEFAULT_CAPACITY
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic        [ple_pkg::CMD_W-1:0]     s_command,
    input  logic        [ple_pkg::POS_W-1:0]     s_item_position,
    input  logic signed [ple_pkg::VAL_W-1:0]     s_item_value,
    input  ple_pkg::ctl_t                        ctl,
    output ple_pkg::sts_t                        sts,
    output logic        [ple_pkg::ST_W-1:0]      m_status,
    output logic        [ple_pkg::FOUND_W-1:0]   m_found_position,
    output logic signed [ple_pkg::VAL_W-1:0]     m_read_value
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;

    logic signed [ple_pkg::VAL_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] pos_reg;
    logic signed [ple_pkg::VAL_W-1:0] val_reg;
    logic [ple_pkg::CMD_W-1:0]   cmd_reg;
    logic [ple_pkg::ST_W-1:0]    st_reg;
    logic [ple_pkg::FOUND_W-1:0] found_reg;
    logic signed [ple_pkg::VAL_W-1:0] value_reg;
    logic signed [ple_pkg::VAL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              rd_pend_reg;
    logic              wr_pend_reg;
    logic              up_reg;

    logic [ple_pkg::ST_W-1:0] pre_st;
    logic [CMP_W-1:0]  pos_ext, cnt_ext;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic signed [ple_pkg::VAL_W-1:0] wr_data;
    logic [CNT_W-1:0]  pos_cnt;
    logic [CNT_W-1:0]  last_idx;

    assign pos_cnt  = CNT_W'(pos_reg);
    assign last_idx = count_reg - CNT_W'(1);

    // range checks on the incoming transaction
    always_comb begin
        pos_ext = CMP_W'(s_item_position);
        cnt_ext = CMP_W'(count_reg);
        case (s_command)
            ple_pkg::CMD_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    pre_st = ple_pkg::ST_BAD_POS;
                end else if (count_reg == CNT_W'(CAPACITY)) begin
                    pre_st = ple_pkg::ST_FULL;
                end else begin
                    pre_st = ple_pkg::ST_OK;
                end
            end
            ple_pkg::CMD_READ, ple_pkg::CMD_REMOVE: begin
                if (count_reg == '0) begin
                    pre_st = ple_pkg::ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    pre_st = ple_pkg::ST_BAD_POS;
                end else begin
                    pre_st = ple_pkg::ST_OK;
                end
            end
            default: begin
                pre_st = (count_reg == '0) ? ple_pkg::ST_EMPTY : ple_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[ADDR_W-1:0];
        if (ctl.rd_pos) begin
            rd_en   = 1'b1;
            rd_addr = pos_reg;
        end else if (ctl.shift_up || ctl.shift_dn) begin
            rd_en = 1'b1;
        end else if (ctl.scan) begin
            rd_en = (idx_reg < count_reg);
        end
    end

    // shift writes land in the cycle after their read
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = val_reg;
        if (ctl.put) begin
            wr_en = 1'b1;
        end else if (wr_pend_reg) begin
            wr_en   = 1'b1;
            wr_addr = up_reg ? rd_addr_reg + ADDR_W'(1) : rd_addr_reg - ADDR_W'(1);
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (ctl.start_up) begin
            idx_next = last_idx;
        end else if (ctl.start_dn) begin
            idx_next = pos_cnt + CNT_W'(1);
        end else if (ctl.start_scan) begin
            idx_next = '0;
        end else if (ctl.shift_up) begin
            idx_next = idx_reg - CNT_W'(1);
        end else if (ctl.shift_dn || ctl.scan) begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.put) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctl.drop) begin
            count_next = last_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            rd_pend_reg <= rd_en;
            wr_pend_reg <= ctl.shift_up || ctl.shift_dn;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (ctl.load) begin
            cmd_reg   <= s_command;
            pos_reg   <= ADDR_W'(s_item_position);
            val_reg   <= s_item_value;
            st_reg    <= pre_st;
            found_reg <= '0;
            value_reg <= '0;
        end
        if (ctl.shift_up) begin
            up_reg <= 1'b1;
        end else if (ctl.shift_dn) begin
            up_reg <= 1'b0;
        end
        if (ctl.hit) begin
            found_reg <= ple_pkg::FOUND_W'(rd_addr_reg);
        end
        if (ctl.miss) begin
            st_reg <= ple_pkg::ST_NOT_FOUND;
        end
        if (ctl.cap_value) begin
            value_reg <= rd_data_reg;
        end
        if (ctl.out_load) begin
            m_status         <= st_reg;
            m_found_position <= found_reg;
            m_read_value     <= value_reg;
        end
    end

    always_comb begin
        sts.cmd        = cmd_reg;
        sts.ok         = (st_reg == ple_pkg::ST_OK);
        sts.ins_direct = (pos_cnt == count_reg);
        sts.rm_direct  = (pos_cnt + CNT_W'(1) == count_reg);
        sts.up_last    = (idx_reg == pos_cnt);
        sts.dn_last    = (idx_reg == last_idx);
        sts.scan_hit   = rd_pend_reg && (rd_data_reg == val_reg);
        sts.scan_end   = rd_pend_reg && (CNT_W'(rd_addr_reg) == last_idx);
    end

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.put && wr_pend_reg))
        else $error("insert write collides with a pending shift write");

    a_count_changes_on_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (count_reg != $past(count_reg))) |-> $past(ctl.put || ctl.drop))
        else $error("entry count changed without insert or remove");

endmodule

FILE: rtl/core/ple_ctrl.sv
module ple_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  ple_pkg::sts_t sts,
    output ple_pkg::ctl_t ctl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_SHIFT_UP = 4'd2;
    localparam logic [3:0] S_UP_FLUSH = 4'd3;
    localparam logic [3:0] S_PUT      = 4'd4;
    localparam logic [3:0] S_SHIFT_DN = 4'd5;
    localparam logic [3:0] S_DN_FLUSH = 4'd6;
    localparam logic [3:0] S_RD_WAIT  = 4'd7;
    localparam logic [3:0] S_SCAN     = 4'd8;
    localparam logic [3:0] S_FINISH   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!sts.ok) begin
                    state_next = S_FINISH;
                end else begin
                    case (sts.cmd)
                        ple_pkg::CMD_INSERT: begin
                            if (sts.ins_direct) begin
                                state_next = S_PUT;
                            end else begin
                                ctl.start_up = 1'b1;
                                state_next   = S_SHIFT_UP;
                            end
                        end
                        ple_pkg::CMD_READ: begin
                            ctl.rd_pos = 1'b1;
                            state_next = S_RD_WAIT;
                        end
                        ple_pkg::CMD_REMOVE: begin
                            if (sts.rm_direct) begin
                                state_next = S_DN_FLUSH;
                            end else begin
                                ctl.start_dn = 1'b1;
                                state_next   = S_SHIFT_DN;
                            end
                        end
                        default: begin
                            ctl.start_scan = 1'b1;
                            state_next     = S_SCAN;
                        end
                    endcase
                end
            end
            S_SHIFT_UP: begin
                ctl.shift_up = 1'b1;
                if (sts.up_last) begin
                    state_next = S_UP_FLUSH;
                end
            end
            S_UP_FLUSH: begin
                state_next = S_PUT;
            end
            S_PUT: begin
                ctl.put    = 1'b1;
                state_next = S_FINISH;
            end
            S_SHIFT_DN: begin
                ctl.shift_dn = 1'b1;
                if (sts.dn_last) begin
                    state_next = S_DN_FLUSH;
                end
            end
            S_DN_FLUSH: begin
                ctl.drop   = 1'b1;
                state_next = S_FINISH;
            end
            S_RD_WAIT: begin
                ctl.cap_value = 1'b1;
                state_next    = S_FINISH;
            end
            S_SCAN: begin
                if (sts.scan_hit) begin
                    ctl.hit    = 1'b1;
                    state_next = S_FINISH;
                end else if (sts.scan_end) begin
                    ctl.miss   = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    ctl.scan = 1'b1;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: rtl/core/positional_list_engine.sv
// Ordered list of signed 32-bit values, up to CAPACITY entries, held in a simple dual-port
// memory (one write, one registered read per cycle). One transaction is processed at a time;
// a finished result sits in the output register while the next command is taken. Shifts and
// searches walk the memory one entry per cycle: read fetches one entry; insert shifts later
// entries up and remove shifts them down, unless the position is at the end of the list; search
// scans from the front to the first hit or the last entry; a rejected command skips all of
// these. Entries are not cleared at reset, only the count is.
module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::DEFAULT_CAPACITY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic        [ple_pkg::CMD_W-1:0]    s_command,
    input  logic        [ple_pkg::POS_W-1:0]    s_item_position,
    input  logic signed [ple_pkg::VAL_W-1:0]    s_item_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [ple_pkg::ST_W-1:0]     m_status,
    output logic        [ple_pkg::FOUND_W-1:0]  m_found_position,
    output logic signed [ple_pkg::VAL_W-1:0]    m_read_value
);

    ple_pkg::ctl_t ctl;
    ple_pkg::sts_t sts;

    ple_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_command        (s_command),
        .s_item_position  (s_item_position),
        .s_item_value     (s_item_value),
        .ctl              (ctl),
        .sts              (sts),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_read_value     (m_read_value)
    );

endmodule

FILE: tb/sv/positional_list_engine_tb.sv
module positional_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = ple_pkg::DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;

    localparam logic signed [ple_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ple_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic        [ple_pkg::ST_W-1:0]    status;
        logic        [ple_pkg::FOUND_W-1:0] found_position;
        logic signed [ple_pkg::VAL_W-1:0]   read_value;
    } list_result_t;

    class list_scoreboard;
        logic signed [ple_pkg::VAL_W-1:0] entries [LIST_DEPTH];
        int                               entry_count;
        list_result_t                     outstanding [$];
        int unsigned                      errors;

        function new();
            entry_count = 0;
            errors      = 0;
        endfunction

        function int unsigned pending();
            return outstanding.size();
        endfunction

        // apply one accepted command to the shadow list and queue its status
        function void note_command(logic [ple_pkg::CMD_W-1:0] cmd,
                                   logic [ple_pkg::POS_W-1:0] pos,
                                   logic signed [ple_pkg::VAL_W-1:0] val);
            list_result_t res;
            int           p;
            int           i;
            res = '0;
            p   = int'(pos);
            case (cmd)
                ple_pkg::CMD_INSERT: begin
                    // position check wins over the full check
                    if (p > entry_count) begin
                        res.status = ple_pkg::ST_BAD_POS;
                    end else if (entry_count >= LIST_DEPTH) begin
                        res.status = ple_pkg::ST_FULL;
                    end else begin
                        for (i = entry_count; i > p; i--)
                            entries[i] = entries[i-1];
                        entries[p] = val;
                        entry_count++;
                        res.status = ple_pkg::ST_OK;
                    end
                end
                ple_pkg::CMD_READ: begin
                    if (entry_count == 0) begin
                        res.status = ple_pkg::ST_EMPTY;
                    end else if (p >= entry_count) begin
                        res.status = ple_pkg::ST_BAD_POS;
                    end else begin
                        res.status     = ple_pkg::ST_OK;
                        res.read_value = entries[p];
                    end
                end
                ple_pkg::CMD_REMOVE: begin
                    if (entry_count == 0) begin
                        res.status = ple_pkg::ST_EMPTY;
                    end else if (p >= entry_count) begin
                        res.status = ple_pkg::ST_BAD_POS;
                    end else begin
                        for (i = p; i + 1 < entry_count; i++)
                            entries[i] = entries[i+1];
                        entry_count--;
                        res.status = ple_pkg::ST_OK;
                    end
                end
                default: begin
                    if (entry_count == 0) begin
                        res.status = ple_pkg::ST_EMPTY;
                    end else begin
                        res.status = ple_pkg::ST_NOT_FOUND;
                        for (i = 0; i < entry_count; i++) begin
                            if (entries[i] == val) begin
                                res.status         = ple_pkg::ST_OK;
                                res.found_position = ple_pkg::FOUND_W'(i);
                                break;
                            end
                        end
                    end
                end
            endcase
            outstanding.push_back(res);
        endfunction

        function void check_result(logic [ple_pkg::ST_W-1:0] st,
                                   logic [ple_pkg::FOUND_W-1:0] fp,
                                   logic signed [ple_pkg::VAL_W-1:0] rv);
            list_result_t want;
            if (outstanding.size() == 0) begin
                $error("result transaction with no command outstanding (status %0d)", st);
                errors++;
                return;
            end
            want = outstanding.pop_front();
            if (st !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, st);
                errors++;
            end
            if (fp !== want.found_position) begin
                $error("found_position: expected %0d, actual %0d", want.found_position, fp);
                errors++;
            end
            if (rv !== want.read_value) begin
                $error("read_value: expected %0d, actual %0d",
                       $signed(want.read_value), $signed(rv));
                errors++;
            end
        endfunction
    endclass

    logic                               aclk;
    logic                               aresetn          = 1'b0;
    logic                               s_valid          = 1'b0;
    logic                               s_ready;
    logic        [ple_pkg::CMD_W-1:0]   s_command        = ple_pkg::CMD_READ;
    logic        [ple_pkg::POS_W-1:0]   s_item_position  = '0;
    logic signed [ple_pkg::VAL_W-1:0]   s_item_value     = '0;
    logic                               m_valid;
    logic                               m_ready          = 1'b0;
    logic        [ple_pkg::ST_W-1:0]    m_status;
    logic        [ple_pkg::FOUND_W-1:0] m_found_position;
    logic signed [ple_pkg::VAL_W-1:0]   m_read_value;

    list_scoreboard board;
    int             send_idle_pct = 23;
    int             recv_idle_pct = 48;
    int             quiet_cycles  = 0;
    int             fill_target   = 0;
    int             target_left   = 0;

    positional_list_engine #(
        .CAPACITY (LIST_DEPTH)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_item_position  (s_item_position),
        .s_item_value     (s_item_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_read_value     (m_read_value)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // result side: check, backpressure, and stall counter for the watchdog
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_status, m_found_position, m_read_value);
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_command(input logic [ple_pkg::CMD_W-1:0] cmd,
                                input logic [ple_pkg::POS_W-1:0] pos,
                                input logic signed [ple_pkg::VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_item_position <= pos;
        s_item_value    <= val;
        do @(posedge aclk); while (!s_ready);
        // note here so the next command is drawn from the updated list
        board.note_command(cmd, pos, val);
    endtask

    // well-formed traffic steered toward a moving fill level, plus some out-of-range noise
    task automatic make_random_command(output logic [ple_pkg::CMD_W-1:0] cmd,
                                       output logic [ple_pkg::POS_W-1:0] pos,
                                       output logic signed [ple_pkg::VAL_W-1:0] val);
        int held;
        int roll;
        int ins_pct;
        int rem_pct;
        held = board.entry_count;
        if (target_left == 0) begin
            roll = $urandom_range(99);
            if (roll < 30)      fill_target = LIST_DEPTH;
            else if (roll < 50) fill_target = 0;
            else if (roll < 75) fill_target = $urandom_range(6, 1);
            else                fill_target = $urandom_range(LIST_DEPTH);
            target_left = $urandom_range(80, 20);
        end
        target_left--;

        if (held < fill_target) begin
            ins_pct = 65;
            rem_pct = 10;
        end else if (held > fill_target) begin
            ins_pct = 10;
            rem_pct = 65;
        end else begin
            ins_pct = 30;
            rem_pct = 25;
        end
        roll = $urandom_range(99);
        if (roll < ins_pct)                cmd = ple_pkg::CMD_INSERT;
        else if (roll < ins_pct + rem_pct) cmd = ple_pkg::CMD_REMOVE;
        else if ($urandom_range(1))        cmd = ple_pkg::CMD_READ;
        else                               cmd = ple_pkg::CMD_SEARCH;

        roll = $urandom_range(99);
        if (roll < 12)
            pos = ple_pkg::POS_W'($urandom_range(2**ple_pkg::POS_W - 1));
        else if (cmd == ple_pkg::CMD_INSERT)
            pos = (roll < 30) ? ple_pkg::POS_W'(held) : ple_pkg::POS_W'($urandom_range(held));
        else if (held == 0)
            pos = '0;
        else
            pos = (roll < 25) ? ple_pkg::POS_W'(held - 1)
                              : ple_pkg::POS_W'($urandom_range(held - 1));

        roll = $urandom_range(99);
        if (cmd == ple_pkg::CMD_SEARCH && held > 0 && roll < 60) begin
            val = board.entries[$urandom_range(held - 1)];
        end else if (roll < 80) begin
            val = $urandom;
        end else begin
            // small pool so duplicates show up and search must return the first hit
            case ($urandom_range(5))
                0:       val = VAL_MIN;
                1:       val = VAL_MAX;
                2:       val = -1;
                default: val = $urandom_range(3);
            endcase
        end
    endtask

    initial begin
        logic        [ple_pkg::CMD_W-1:0] cmd;
        logic        [ple_pkg::POS_W-1:0] pos;
        logic signed [ple_pkg::VAL_W-1:0] val;
        int                               i;
        int                               ph;

        board = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list, then insert past the end
        send_command(ple_pkg::CMD_SEARCH, 0, 0);
        send_command(ple_pkg::CMD_READ,   0, VAL_MAX);
        send_command(ple_pkg::CMD_REMOVE, 0, 0);
        send_command(ple_pkg::CMD_INSERT, 1, 5);
        send_command(ple_pkg::CMD_INSERT, 127, VAL_MIN);
        // build [-1, max, 0, min] through front, end and middle inserts
        send_command(ple_pkg::CMD_INSERT, 0, VAL_MAX);
        send_command(ple_pkg::CMD_INSERT, 1, VAL_MIN);
        send_command(ple_pkg::CMD_INSERT, 1, 0);
        send_command(ple_pkg::CMD_INSERT, 0, -1);
        for (i = 0; i < 4; i++)
            send_command(ple_pkg::CMD_READ, ple_pkg::POS_W'(i), $urandom);
        send_command(ple_pkg::CMD_READ,   4, 0);
        send_command(ple_pkg::CMD_READ,   127, -1);
        send_command(ple_pkg::CMD_SEARCH, 0, VAL_MIN);
        send_command(ple_pkg::CMD_INSERT, 4, -1);
        send_command(ple_pkg::CMD_SEARCH, 3, -1);
        send_command(ple_pkg::CMD_SEARCH, 127, 12345);
        send_command(ple_pkg::CMD_REMOVE, 5, 0);
        send_command(ple_pkg::CMD_REMOVE, 127, 0);
        send_command(ple_pkg::CMD_REMOVE, 1, VAL_MAX);
        send_command(ple_pkg::CMD_REMOVE, 3, 0);
        send_command(ple_pkg::CMD_REMOVE, 0, 0);
        send_command(ple_pkg::CMD_READ,   0, VAL_MIN);

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 23;
                    recv_idle_pct = 48;
                end
                1: begin
                    send_idle_pct = 48;
                    recv_idle_pct = 23;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (i = 0; i < RANDOM_ITEMS / 3; i++) begin
                make_random_command(cmd, pos, val);
                send_command(cmd, pos, val);
            end
        end

        s_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
